@@ rtl/assert_macros.svh @@
// Assertion macros shared by the FFT engine RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/r2fft_pkg.sv @@
// Types and constants for the radix-2 FFT engine.
// No dependencies.
`default_nettype none
package r2fft_pkg;
	localparam int TW_BITS = 16;
	localparam int SAMPLE_BITS = 16;

	// one input sample word, Q1.15 real and imaginary
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_real;
		logic [SAMPLE_BITS-1:0] sample_imag;
	} sample_word_t;

	// one output bin word, frame_end set on the last bin
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] bin_real;
		logic [SAMPLE_BITS-1:0] bin_imag;
		logic                   frame_end;
	} bin_word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_A,
		ST_RD_B,
		ST_CALC,
		ST_WR_B,
		ST_EMIT_RD,
		ST_EMIT
	} fft_state_t;

	// Q1.15 twiddle for angle k*step, k < n/2; returns {cos, sin}
	function automatic logic [31:0] twiddle(input int k, input real step);
		real ang;
		real c;
		real s;
		int ci;
		int si;
		ang = step * real'(k);
		c = $cos(ang) * 32768.0;
		s = $sin(ang) * 32768.0;
		ci = (c >= 0.0) ? int'($floor(c + 0.5)) : -int'($floor(-c + 0.5));
		si = (s >= 0.0) ? int'($floor(s + 0.5)) : -int'($floor(-s + 0.5));
		if (ci > 32767) ci = 32767;
		if (si > 32767) si = 32767;
		twiddle = {ci[15:0], si[15:0]};
	endfunction
endpackage
`default_nettype wire

@@ rtl/r2fft_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module r2fft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/radix2_fft_engine.sv @@
// Top level of the radix-2 decimation-in-time FFT engine.
// Depends on r2fft_pkg, r2fft_ram and assert_macros.svh.
//
// Samples are taken one per cycle while busy is low; the POINTS-th sample of a
// frame raises busy, the engine runs log2(POINTS) stages in place on one RAM
// (each butterfly steps through read upper, read lower, compute and write upper,
// write lower, as the RAM has a single port pair), then issues POINTS bins,
// each read in EMIT_RD and then shown for one cycle with strobe high and
// frame_end on the last. The receiver cannot stall. Samples of a new frame are
// taken only after the last bin. The output is scaled by 1/POINTS in both
// directions; direction is taken from cfg_data while busy is low.
`default_nettype none
`include "assert_macros.svh"
module radix2_fft_engine
	import r2fft_pkg::*;
#(
	parameter int POINTS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output      logic                     busy,
	input  wire sample_word_t             sample_word,
	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic                     cfg_data,
	output      logic                     strobe,
	output      bin_word_t                bin_word
);
	localparam int AW = $clog2(POINTS);
	localparam int SW = (AW > 1) ? $clog2(AW) : 1;
	localparam int DW = 2 * SAMPLE_BITS;
	localparam int PW = SAMPLE_BITS + TW_BITS + 1;
	localparam int HALF = POINTS / 2;
	localparam int TIW = (AW > 1) ? AW - 1 : 1;
	localparam real TW_STEP = 6.283185307179586 / POINTS;

	fft_state_t state_q, state_d;
	logic [AW-1:0] load_q;
	logic [SW-1:0] stage_q;
	logic [AW-1:0] bfly_q;
	logic [AW-1:0] emit_q;
	logic          dir_q;
	logic          in_acc;

	// twiddle table, built at elaboration
	logic [31:0] tw_rom [HALF];
	for (genvar g = 0; g < HALF; g++) begin : g_tw
		assign tw_rom[g] = twiddle(g, TW_STEP);
	end

	// butterfly addressing: bfly_q counts butterflies in a stage
	logic [AW-1:0] half_m, p_addr, q_addr, k_idx, tw_idx;
	logic [AW:0]   bshift;
	always_comb begin
		half_m = AW'(({{AW{1'b0}}, 1'b1} << stage_q) - 1'b1);
		k_idx  = bfly_q & half_m;
		bshift = {1'b0, bfly_q & ~half_m} << 1;
		p_addr = bshift[AW-1:0] | k_idx;
		q_addr = p_addr | AW'(half_m + 1'b1);
		tw_idx = AW'(k_idx << (SW'(AW - 1) - stage_q));
	end

	// bit-reversed load address
	logic [AW-1:0] load_rev;
	always_comb begin
		for (int i = 0; i < AW; i++) begin
			load_rev[i] = load_q[AW-1-i];
		end
	end

	// RAM port control
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic [SAMPLE_BITS-1:0] up_re_q, up_im_q, lo_re_q, lo_im_q;
	logic [DW-1:0] a_q;

	r2fft_ram #(.WIDTH(DW), .DEPTH(POINTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign in_acc    = start && !busy;
	assign busy      = (state_q != ST_LOAD);
	assign cfg_ready = !busy;

	// next state
	logic last_bfly, last_stage;
	assign last_bfly  = (bfly_q == AW'(HALF - 1));
	assign last_stage = (stage_q == SW'(AW - 1));
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (in_acc && load_q == AW'(POINTS - 1)) state_d = ST_RD_A;
			ST_RD_A:    state_d = ST_RD_B;
			ST_RD_B:    state_d = ST_CALC;
			ST_CALC:    state_d = ST_WR_B;
			ST_WR_B: begin
				if (last_bfly && last_stage) state_d = ST_EMIT_RD;
				else state_d = ST_RD_A;
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_q == AW'(POINTS - 1)) state_d = ST_LOAD;
				else state_d = ST_EMIT_RD;
			end
			default:    state_d = ST_LOAD;
		endcase
	end

	// butterfly arithmetic on registered operands
	logic signed [TW_BITS-1:0] wr, wi;
	logic signed [PW:0] pr, pi_;
	logic signed [SAMPLE_BITS+TW_BITS-1:0] m_rr, m_ii, m_ri, m_ir;
	logic signed [SAMPLE_BITS+1:0] tr, ti, sa_re, sa_im, sb_re, sb_im;
	logic [SAMPLE_BITS-1:0] na_re, na_im, nb_re, nb_im;
	logic signed [TW_BITS-1:0] tw_c, tw_s;
	logic signed [SAMPLE_BITS-1:0] br, bi, ar, ai;

	function automatic logic [SAMPLE_BITS-1:0] sat_half(input logic signed [SAMPLE_BITS+1:0] v);
		logic signed [SAMPLE_BITS+1:0] h;
		h = (v + $signed((SAMPLE_BITS+2)'(1))) >>> 1;
		if (h > $signed((SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1)))
			sat_half = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (h < -$signed((SAMPLE_BITS+2)'(1 << (SAMPLE_BITS-1))))
			sat_half = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			sat_half = h[SAMPLE_BITS-1:0];
	endfunction

	logic [31:0] tw_word;
	assign tw_word = tw_rom[tw_idx[TIW-1:0]];
	always_comb begin
		tw_c = $signed(tw_word[31:16]);
		tw_s = $signed(tw_word[15:0]);
		wr = tw_c;
		wi = dir_q ? tw_s : -tw_s;
		br = $signed(lo_re_q);
		bi = $signed(lo_im_q);
		ar = $signed(up_re_q);
		ai = $signed(up_im_q);
		// full-width products before rounding back to Q1.15
		m_rr = br * wr;
		m_ii = bi * wi;
		m_ri = br * wi;
		m_ir = bi * wr;
		pr  = (PW+1)'(m_rr) - (PW+1)'(m_ii) + (PW+1)'(1 << 14);
		pi_ = (PW+1)'(m_ri) + (PW+1)'(m_ir) + (PW+1)'(1 << 14);
		tr = (SAMPLE_BITS+2)'(pr >>> 15);
		ti = (SAMPLE_BITS+2)'(pi_ >>> 15);
		sa_re = (SAMPLE_BITS+2)'(ar) + tr;
		sa_im = (SAMPLE_BITS+2)'(ai) + ti;
		sb_re = (SAMPLE_BITS+2)'(ar) - tr;
		sb_im = (SAMPLE_BITS+2)'(ai) - ti;
		na_re = sat_half(sa_re);
		na_im = sat_half(sa_im);
		nb_re = sat_half(sb_re);
		nb_im = sat_half(sb_im);
	end

	// RAM port selection
	always_comb begin
		we = 1'b0;
		waddr = p_addr;
		wdata = {up_re_q, up_im_q};
		raddr = p_addr;
		unique case (state_q)
			ST_LOAD: begin
				we = in_acc;
				waddr = load_rev;
				wdata = {sample_word.sample_real, sample_word.sample_imag};
			end
			ST_RD_A:    raddr = p_addr;
			ST_RD_B:    raddr = q_addr;
			ST_CALC: begin
				we = 1'b1;
				waddr = p_addr;
				wdata = {na_re, na_im};
			end
			ST_WR_B: begin
				we = 1'b1;
				waddr = q_addr;
				wdata = a_q;
			end
			ST_EMIT_RD: raddr = emit_q;
			ST_EMIT:    raddr = emit_q;
			default:    we = 1'b0;
		endcase
	end

	// operand capture; the upper read lands in RD_B, the lower in CALC
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_B) begin
			up_re_q <= rdata[DW-1:SAMPLE_BITS];
			up_im_q <= rdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_CALC) begin
			a_q <= {nb_re, nb_im};
		end
	end
	always_comb begin
		lo_re_q = rdata[DW-1:SAMPLE_BITS];
		lo_im_q = rdata[SAMPLE_BITS-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			stage_q <= '0;
			bfly_q  <= '0;
			emit_q  <= '0;
			dir_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) dir_q <= cfg_data;
			if (in_acc) load_q <= load_q + 1'b1;
			if (state_q == ST_WR_B) begin
				bfly_q <= last_bfly ? '0 : bfly_q + 1'b1;
				if (last_bfly) stage_q <= last_stage ? '0 : stage_q + 1'b1;
			end
			if (state_q == ST_EMIT) emit_q <= emit_q + 1'b1;
		end
	end

	// output word: RAM data is valid in the EMIT cycle
	always_comb begin
		strobe             = (state_q == ST_EMIT);
		bin_word.bin_real  = rdata[DW-1:SAMPLE_BITS];
		bin_word.bin_imag  = rdata[SAMPLE_BITS-1:0];
		bin_word.frame_end = strobe && (emit_q == AW'(POINTS - 1));
	end

	`ASSERT_IMPL(a_no_load_busy, clk, arst_n, busy, !we || state_q != ST_LOAD)
	`ASSERT_IMPL(a_end_strobe, clk, arst_n, bin_word.frame_end, strobe)
	`ASSERT_NEXT(a_end_idle, clk, arst_n, bin_word.frame_end, !busy)
endmodule
`default_nettype wire
